// ----- src/cpba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_pkg: shared definitions for the page bitmap allocator
// Map geometry, field widths, status and operation codes, unit result type.
// ----------------------------------------------------------------------------
package cpba_pkg;

    localparam int unsigned NUM_PAGES = 16384;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned MAP_WORDS = NUM_PAGES / WORD_BITS;
    localparam int unsigned PAGE_W    = $clog2(NUM_PAGES);
    localparam int unsigned COUNT_W   = PAGE_W + 1;
    localparam int unsigned WIDX_W    = $clog2(MAP_WORDS);
    localparam int unsigned BIT_W     = $clog2(WORD_BITS);
    localparam int unsigned LEN_W     = BIT_W + 1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NO_SPACE  = 2'd1;
    localparam t_status ST_NOT_ALLOC = 2'd2;
    localparam t_status ST_RANGE     = 2'd3;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // One uniform stretch of a map entry, starting at the current bit.
    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } t_run;

endpackage
`default_nettype wire

// ----- src/cpba_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_if: request and response channels of the page bitmap allocator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cpba_req_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [cpba_pkg::PAGE_W-1:0]    start_page;
    logic [cpba_pkg::COUNT_W-1:0]   page_count;

    modport source (output valid, operation, start_page, page_count, input ready);
    modport sink   (input valid, operation, start_page, page_count, output ready);
endinterface

interface cpba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [cpba_pkg::PAGE_W-1:0]    first_page;

    modport source (output valid, status, first_page, input ready);
    modport sink   (input valid, status, first_page, output ready);
endinterface
`default_nettype wire

// ----- src/cpba_run_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_run_unit: run length finder for one map entry
// Measures the stretch of equal bits from a start bit up to the entry's top.
// ----------------------------------------------------------------------------
module cpba_run_unit (
    input  wire logic [cpba_pkg::WORD_BITS-1:0] i_word,
    input  wire logic [cpba_pkg::BIT_W-1:0]     i_bit,
    output cpba_pkg::t_run                      o_run
);

    logic                           cur;
    logic [cpba_pkg::WORD_BITS-1:0] diff;
    logic [cpba_pkg::WORD_BITS-1:0] rem;
    logic [cpba_pkg::LEN_W-1:0]     len;

    // Mark bits that differ from the start bit, then pad above the top of the entry.
    assign cur  = i_word[i_bit];
    assign diff = cur ? ~i_word : i_word;
    assign rem  = (diff >> i_bit) | ~({cpba_pkg::WORD_BITS{1'b1}} >> i_bit);

    always_comb begin
        len = cpba_pkg::LEN_W'(cpba_pkg::WORD_BITS);
        for (int i = cpba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (rem[i]) begin
                len = cpba_pkg::LEN_W'(i);
            end
        end
    end

    assign o_run.used = cur;
    assign o_run.len  = len;

endmodule
`default_nettype wire

// ----- src/contiguous_page_bitmap_allocator.sv -----
`default_nettype none
// Allocate walks the map one uniform stretch at a time (one per map entry when
//   entries are all free or all used), then writes each fully covered entry
//   directly and read-modify-writes each partly covered entry to mark the run.
// Free read-modify-writes each map entry touched. One request in flight.
// Reset clears the 512-entry map; requests wait until it is done.
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator: first-fit contiguous page allocator
// One occupancy bit per page in a 512 x 32 map memory. Allocate walks the
// map with a shared run-length unit; free clears pages in order and stops at
// the first page that is not set.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpba_req_if.sink   i_req,
    cpba_rsp_if.source o_rsp
);

    localparam int unsigned WB = cpba_pkg::WORD_BITS;
    localparam int unsigned PW = cpba_pkg::PAGE_W;
    localparam int unsigned CW = cpba_pkg::COUNT_W;
    localparam int unsigned XW = cpba_pkg::WIDX_W;
    localparam int unsigned BW = cpba_pkg::BIT_W;
    localparam int unsigned LW = cpba_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SPAN,
        S_WORD,
        S_RMW,
        S_RESULT
    } t_state;

    // Map memory: one registered read port, one write port.
    logic [WB-1:0] r_map [cpba_pkg::MAP_WORDS];
    logic [WB-1:0] r_rdata;
    logic          mem_we;
    logic [XW-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic          mem_re;
    logic [XW-1:0] mem_raddr;

    t_state              r_state,     n_state;
    cpba_pkg::t_op       r_op,        n_op;
    logic [PW-1:0]       r_start,     n_start;
    logic [CW-1:0]       r_count,     n_count;
    logic [PW-1:0]       r_end,       n_end;
    logic [XW-1:0]       r_wi,        n_wi;
    logic [BW-1:0]       r_bp,        n_bp;
    logic [CW-1:0]       r_run,       n_run;
    cpba_pkg::t_status   r_status,    n_status;
    logic [PW-1:0]       r_first,     n_first;
    logic                r_out_valid, n_out_valid;
    cpba_pkg::t_status   r_out_status, n_out_status;
    logic [PW-1:0]       r_out_first, n_out_first;

    cpba_pkg::t_run run;

    // Scan arithmetic
    logic [LW-1:0]   bp_next;
    logic [CW-1:0]   run_sum;
    logic [CW-1:0]   found_start;
    logic [CW:0]     free_limit;

    // Per-entry mask of the run being marked or freed
    logic [BW-1:0]   mask_lo;
    logic [BW-1:0]   mask_hi;
    logic [WB-1:0]   mask;
    logic            last_word;
    logic [WB-1:0]   bad;
    logic [WB-1:0]   bad_low;
    logic [WB-1:0]   clr_mask;

    cpba_run_unit u_run (
        .i_word (r_rdata),
        .i_bit  (r_bp),
        .o_run  (run)
    );

    assign bp_next     = LW'(r_bp) + run.len;
    assign run_sum     = r_run + CW'(run.len);
    assign found_start = CW'({r_wi, r_bp}) - r_run;
    assign free_limit  = (CW+1)'(r_start) + (CW+1)'(r_count);

    assign mask_lo   = (r_wi == r_start[PW-1:BW]) ? r_start[BW-1:0] : '0;
    assign mask_hi   = (r_wi == r_end[PW-1:BW])   ? r_end[BW-1:0]   : BW'(WB - 1);
    assign mask      = ({WB{1'b1}} << mask_lo) & ({WB{1'b1}} >> (BW'(WB - 1) - mask_hi));
    assign last_word = (r_wi == r_end[PW-1:BW]);

    // Pages in the run that are not set; clear only the pages below the first one.
    assign bad      = ~r_rdata & mask;
    assign bad_low  = bad & (~bad + WB'(1));
    assign clr_mask = mask & (bad_low - WB'(1));

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.first_page = r_out_first;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_start      = r_start;
        n_count      = r_count;
        n_end        = r_end;
        n_wi         = r_wi;
        n_bp         = r_bp;
        n_run        = r_run;
        n_status     = r_status;
        n_first      = r_first;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_first  = r_out_first;
        mem_we       = 1'b0;
        mem_waddr    = r_wi;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_wi;

        case (r_state)
            S_CLEAR: begin
                // Sweep the map to all free, one entry a cycle.
                mem_we = 1'b1;
                if (r_wi == XW'(cpba_pkg::MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_wi = r_wi + XW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = cpba_pkg::t_op'(i_req.operation);
                    n_start = i_req.start_page;
                    n_count = i_req.page_count;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_first = '0;
                if (r_op == cpba_pkg::OP_ALLOC) begin
                    if (r_count == '0) begin
                        n_status = cpba_pkg::ST_RANGE;
                        n_state  = S_RESULT;
                    end else if (r_count > CW'(cpba_pkg::NUM_PAGES)) begin
                        n_status = cpba_pkg::ST_NO_SPACE;
                        n_state  = S_RESULT;
                    end else begin
                        // Fetch entry 0 and start the walk.
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_wi      = '0;
                        n_bp      = '0;
                        n_run     = '0;
                        n_state   = S_SCAN;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = cpba_pkg::ST_OK;
                        n_state  = S_RESULT;
                    end else if (free_limit > (CW+1)'(cpba_pkg::NUM_PAGES)) begin
                        n_status = cpba_pkg::ST_RANGE;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_SPAN;
                    end
                end
            end
            S_SCAN: begin
                if (run.used) begin
                    n_run = '0;
                end else begin
                    n_run = run_sum;
                end
                if (!run.used && run_sum >= r_count) begin
                    // Run complete: it began r_run pages before the current bit.
                    n_start = found_start[PW-1:0];
                    n_first = found_start[PW-1:0];
                    n_state = S_SPAN;
                end else if (bp_next[BW]) begin
                    if (r_wi == XW'(cpba_pkg::MAP_WORDS - 1)) begin
                        n_status = cpba_pkg::ST_NO_SPACE;
                        n_first  = '0;
                        n_state  = S_RESULT;
                    end else begin
                        // Advance to the next entry; its data arrives next cycle.
                        mem_re    = 1'b1;
                        mem_raddr = r_wi + XW'(1);
                        n_wi      = r_wi + XW'(1);
                        n_bp      = '0;
                    end
                end else begin
                    n_bp = bp_next[BW-1:0];
                end
            end
            S_SPAN: begin
                n_end   = PW'(CW'(r_start) + r_count - CW'(1));
                n_wi    = r_start[PW-1:BW];
                n_state = S_WORD;
            end
            S_WORD: begin
                if (r_op == cpba_pkg::OP_ALLOC && mask == {WB{1'b1}}) begin
                    // Fully covered entry was all free: write it used without a read.
                    mem_we    = 1'b1;
                    mem_wdata = {WB{1'b1}};
                    if (last_word) begin
                        n_status = cpba_pkg::ST_OK;
                        n_state  = S_RESULT;
                    end else begin
                        n_wi = r_wi + XW'(1);
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                mem_we = 1'b1;
                if (r_op == cpba_pkg::OP_ALLOC) begin
                    mem_wdata = r_rdata | mask;
                    if (last_word) begin
                        n_status = cpba_pkg::ST_OK;
                        n_state  = S_RESULT;
                    end else begin
                        n_wi    = r_wi + XW'(1);
                        n_state = S_WORD;
                    end
                end else if (bad == '0) begin
                    mem_wdata = r_rdata & ~mask;
                    if (last_word) begin
                        n_status = cpba_pkg::ST_OK;
                        n_state  = S_RESULT;
                    end else begin
                        n_wi    = r_wi + XW'(1);
                        n_state = S_WORD;
                    end
                end else begin
                    // Stop at the first page not set; keep the pages below it cleared.
                    mem_wdata = r_rdata & ~clr_mask;
                    n_status  = cpba_pkg::ST_NOT_ALLOC;
                    n_state   = S_RESULT;
                end
            end
            S_RESULT: begin
                // Hold until the response register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_first  = r_first;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wi        <= n_wi;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_start      <= n_start;
        r_count      <= n_count;
        r_end        <= n_end;
        r_bp         <= n_bp;
        r_run        <= n_run;
        r_status     <= n_status;
        r_first      <= n_first;
        r_out_status <= n_out_status;
        r_out_first  <= n_out_first;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_map[mem_raddr];
        end
    end

endmodule
`default_nettype wire
